/* hdl/lbc_pkg.sv */
// ----------------------------------------------------------------------------
// lbc_pkg
// shared types for the line box clip pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbc_pkg;

    // pipeline control handed from the core to its divider stages
    typedef struct packed {
        logic advance;
        logic valid;
    } lbc_stage_ctl_t;

endpackage

`default_nettype wire

/* hdl/lbc_rdiv_pair.sv */
// ----------------------------------------------------------------------------
// lbc_rdiv_pair
// two-lane pipelined rounded divider: q = (a*b + d/2) / d, capped at
// 2^(COORD_BITS+1); one multiply stage, one rounding stage, then one
// restoring quotient bit per stage, with a sideband carried alongside
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbc_rdiv_pair #(
    parameter int COORD_BITS = 16,
    parameter int SIDE_BITS  = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lbc_pkg::lbc_stage_ctl_t             ctl,
    input  logic [1:0][COORD_BITS+1:0]          a_in,
    input  logic [1:0][COORD_BITS:0]            b_in,
    input  logic [1:0][COORD_BITS:0]            d_in,
    input  logic [SIDE_BITS-1:0]                side_in,
    output logic                                valid_out,
    output logic [1:0][COORD_BITS+1:0]          q_out,
    output logic [SIDE_BITS-1:0]                side_out
);

    import lbc_pkg::*;

    localparam int AW = COORD_BITS + 2;
    localparam int DW = COORD_BITS + 1;
    localparam int QB = COORD_BITS + 2;
    localparam int PD = AW + DW;
    localparam int PW = PD + 1;
    localparam logic [QB-1:0] QUOT_CAP = QB'(1) << (QB - 1);

    logic [QB+1:0]          valid_reg;
    logic [SIDE_BITS-1:0]   side_reg [0:QB+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.advance)
        begin
            valid_reg <= {valid_reg[QB:0], ctl.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k <= QB + 1; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign valid_out = valid_reg[QB+1];
    assign side_out  = side_reg[QB+1];

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic [PD-1:0]  prod_next;
        logic [PD-1:0]  prod_reg;
        logic [DW-1:0]  dm_reg;
        logic [PW-1:0]  p_sum;
        logic [DW-1:0]  rem_reg  [0:QB-1];
        logic [DW-1:0]  rem_next [0:QB-1];
        logic [QB-1:0]  low_reg  [0:QB-1];
        logic [QB-1:0]  low_next [0:QB-1];
        logic [DW-1:0]  d_reg    [0:QB-1];
        logic [DW-1:0]  d_next   [0:QB-1];
        logic [QB-1:0]  q_reg    [0:QB];
        logic [QB-1:0]  q_next   [0:QB];
        logic           sat_reg  [0:QB];
        logic           sat_next [0:QB];
        logic [DW:0]    trial    [1:QB];
        logic [DW:0]    diff     [1:QB];
        logic           ge       [1:QB];
        logic [QB-1:0]  q_raw;

        assign prod_next = PD'(a_in[l]) * PD'(b_in[l]);

        always_comb
        begin
            p_sum       = PW'(prod_reg) + PW'(dm_reg >> 1);
            rem_next[0] = p_sum[QB+DW-1:QB];
            low_next[0] = p_sum[QB-1:0];
            d_next[0]   = dm_reg;
            q_next[0]   = '0;
            sat_next[0] = p_sum[PW-1:QB] >= (PW-QB)'(dm_reg);
            for (int k = 1; k <= QB; k++)
            begin
                trial[k]    = {rem_reg[k-1], low_reg[k-1][QB-1]};
                ge[k]       = trial[k] >= {1'b0, d_reg[k-1]};
                diff[k]     = trial[k] - {1'b0, d_reg[k-1]};
                q_next[k]   = {q_reg[k-1][QB-2:0], ge[k]};
                sat_next[k] = sat_reg[k-1];
            end
            for (int k = 1; k < QB; k++)
            begin
                rem_next[k] = ge[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
                low_next[k] = low_reg[k-1] << 1;
                d_next[k]   = d_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.advance)
            begin
                prod_reg <= prod_next;
                dm_reg   <= d_in[l];
                for (int k = 0; k < QB; k++)
                begin
                    rem_reg[k] <= rem_next[k];
                    low_reg[k] <= low_next[k];
                    d_reg[k]   <= d_next[k];
                end
                for (int k = 0; k <= QB; k++)
                begin
                    q_reg[k]   <= q_next[k];
                    sat_reg[k] <= sat_next[k];
                end
            end
        end

        assign q_raw    = q_reg[QB];
        assign q_out[l] = (sat_reg[QB] || (q_raw[QB-1] && (|q_raw[QB-2:0])))
                          ? QUOT_CAP : q_raw;
    end

endmodule

`default_nettype wire

/* hdl/line_box_clip_core.sv */
// ----------------------------------------------------------------------------
// line_box_clip_core
// clips one line segment against one inclusive box per transaction
// ----------------------------------------------------------------------------
// usage
//   item channel: item_valid / item_stall carry a segment, left end first,
//   and the box limits; a transaction completes when item_valid is high and
//   item_stall is low at a rising edge of clk
//   result channel: result_valid / result_stall carry the clipped endpoints,
//   their border flags and the visible flag, in input order
//   endpoint fields are zero when their border flag is clear
//   pipeline from accept to result_valid: an input stage, two chained
//   divider pipelines of COORD_BITS+4 stages each (x clip then y clip)
//   and the output register
//   throughput: one transaction per cycle while no result is stalled, set by
//   the one-quotient-bit-per-stage divider pipelines
//   a stalled result holds the whole pipeline in place; item_stall is high
//   only while a result is waiting and result_stall is high
//   reset empties the pipeline; no state survives between transactions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module line_box_clip_core #(
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic signed [COORD_BITS-1:0]  line_left_x,
    input  logic signed [COORD_BITS-1:0]  line_left_y,
    input  logic signed [COORD_BITS-1:0]  line_right_x,
    input  logic signed [COORD_BITS-1:0]  line_right_y,
    input  logic signed [COORD_BITS-1:0]  box_x_low,
    input  logic signed [COORD_BITS-1:0]  box_y_low,
    input  logic signed [COORD_BITS-1:0]  box_x_high,
    input  logic signed [COORD_BITS-1:0]  box_y_high,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          visible,
    output logic signed [COORD_BITS-1:0]  first_x,
    output logic signed [COORD_BITS-1:0]  first_y,
    output logic                          first_on_border,
    output logic signed [COORD_BITS-1:0]  second_x,
    output logic signed [COORD_BITS-1:0]  second_y,
    output logic                          second_on_border
);

    import lbc_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int DW = CW + 1;
    localparam int AW = CW + 2;
    localparam int YW = CW + 3;

    typedef struct packed {
        logic                  rej;
        logic                  neg;
        logic                  clip1;
        logic                  clip2;
        logic signed [CW-1:0]  x1;
        logic signed [CW-1:0]  y1;
        logic signed [CW-1:0]  x2;
        logic signed [CW-1:0]  y2;
        logic signed [CW-1:0]  bx0;
        logic signed [CW-1:0]  bx1;
        logic signed [CW-1:0]  by0;
        logic signed [CW-1:0]  by1;
        logic [DW-1:0]         delx;
        logic [DW-1:0]         dely;
    } xside_t;

    typedef struct packed {
        logic                  rej;
        logic                  c3;
        logic                  c4;
        logic signed [CW-1:0]  x1;
        logic signed [CW-1:0]  x2;
        logic signed [YW-1:0]  y1;
        logic signed [YW-1:0]  y2;
        logic signed [CW-1:0]  bx0;
        logic signed [CW-1:0]  bx1;
        logic signed [CW-1:0]  by0;
        logic signed [CW-1:0]  by1;
    } yside_t;

    localparam int XSW = $bits(xside_t);
    localparam int YSW = $bits(yside_t);

    lbc_stage_ctl_t        x_ctl;
    lbc_stage_ctl_t        y_ctl;
    logic                  advance;

    // input stage
    logic                  s0_valid_reg;
    logic signed [CW-1:0]  s0_x1_reg, s0_y1_reg, s0_x2_reg, s0_y2_reg;
    logic signed [CW-1:0]  s0_bx0_reg, s0_by0_reg, s0_bx1_reg, s0_by1_reg;

    // output register
    logic                  result_valid_reg;
    logic                  visible_reg, visible_next;
    logic signed [CW-1:0]  first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic signed [CW-1:0]  second_x_reg, second_x_next, second_y_reg, second_y_next;
    logic                  first_ok_reg, first_ok_next, second_ok_reg, second_ok_next;

    assign advance    = !(result_valid_reg && result_stall);
    assign item_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_x1_reg  <= line_left_x;
            s0_y1_reg  <= line_left_y;
            s0_x2_reg  <= line_right_x;
            s0_y2_reg  <= line_right_y;
            s0_bx0_reg <= box_x_low;
            s0_by0_reg <= box_y_low;
            s0_bx1_reg <= box_x_high;
            s0_by1_reg <= box_y_high;
        end
    end

    // x clip setup
    logic signed [DW-1:0]     x1d, x2d, y1d, y2d, bx0d, bx1d;
    logic signed [DW-1:0]     delx_s, dely_s, a0_s, a1_s;
    logic [DW-1:0]            dely_u;
    logic                     neg, clip1, clip2, delx_zero;
    xside_t                   xs_next;
    logic [1:0][AW-1:0]       x_a;
    logic [1:0][DW-1:0]       x_b, x_d;
    logic                     x_valid;
    logic [1:0][AW-1:0]       x_q;
    logic [XSW-1:0]           x_side_out;
    xside_t                   xo;

    assign x1d       = DW'(s0_x1_reg);
    assign x2d       = DW'(s0_x2_reg);
    assign y1d       = DW'(s0_y1_reg);
    assign y2d       = DW'(s0_y2_reg);
    assign bx0d      = DW'(s0_bx0_reg);
    assign bx1d      = DW'(s0_bx1_reg);
    assign delx_s    = x2d - x1d;
    assign dely_s    = y2d - y1d;
    assign neg       = dely_s[DW-1];
    assign dely_u    = neg ? DW'(-dely_s) : DW'(dely_s);
    assign clip1     = s0_x1_reg < s0_bx0_reg;
    assign clip2     = s0_x2_reg > s0_bx1_reg;
    assign delx_zero = delx_s == '0;
    assign a0_s      = bx0d - x1d;
    assign a1_s      = x2d - bx1d;

    always_comb
    begin
        xs_next.rej   = delx_s[DW-1]
                      || (clip1 ? delx_zero : (s0_x1_reg > s0_bx1_reg))
                      || (clip2 ? delx_zero : (s0_x2_reg < s0_bx0_reg));
        xs_next.neg   = neg;
        xs_next.clip1 = clip1;
        xs_next.clip2 = clip2;
        xs_next.x1    = s0_x1_reg;
        xs_next.y1    = s0_y1_reg;
        xs_next.x2    = s0_x2_reg;
        xs_next.y2    = s0_y2_reg;
        xs_next.bx0   = s0_bx0_reg;
        xs_next.bx1   = s0_bx1_reg;
        xs_next.by0   = s0_by0_reg;
        xs_next.by1   = s0_by1_reg;
        xs_next.delx  = DW'(delx_s);
        xs_next.dely  = dely_u;
    end

    assign x_a[0] = {1'b0, a0_s};
    assign x_a[1] = {1'b0, a1_s};
    assign x_b[0] = dely_u;
    assign x_b[1] = dely_u;
    assign x_d[0] = DW'(delx_s);
    assign x_d[1] = DW'(delx_s);

    assign x_ctl.advance = advance;
    assign x_ctl.valid   = s0_valid_reg;

    lbc_rdiv_pair #(
        .COORD_BITS (COORD_BITS),
        .SIDE_BITS  (XSW)
    ) u_xdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (x_ctl),
        .a_in      (x_a),
        .b_in      (x_b),
        .d_in      (x_d),
        .side_in   (xs_next),
        .valid_out (x_valid),
        .q_out     (x_q),
        .side_out  (x_side_out)
    );

    assign xo = xside_t'(x_side_out);

    // y clip setup
    logic signed [YW-1:0]     t0, t1, y1e, y2e, by0e, by1e, y1w, y2w;
    logic signed [YW:0]       a2_s, a3_s;
    logic                     up, c3, c4, r3, r4, dely_zero;
    yside_t                   ys_next;
    logic [1:0][AW-1:0]       y_a;
    logic [1:0][DW-1:0]       y_b, y_d;
    logic                     y_valid;
    logic [1:0][AW-1:0]       y_q;
    logic [YSW-1:0]           y_side_out;
    yside_t                   yo;

    assign t0        = {1'b0, x_q[0]};
    assign t1        = {1'b0, x_q[1]};
    assign y1e       = YW'(xo.y1);
    assign y2e       = YW'(xo.y2);
    assign by0e      = YW'(xo.by0);
    assign by1e      = YW'(xo.by1);
    assign y1w       = xo.clip1 ? (xo.neg ? y1e - t0 : y1e + t0) : y1e;
    assign y2w       = xo.clip2 ? (xo.neg ? y2e + t1 : y2e - t1) : y2e;
    assign up        = y2w > y1w;
    assign dely_zero = xo.dely == '0;

    always_comb
    begin
        if (up)
        begin
            c3   = y1w < by0e;
            a2_s = (YW+1)'(by0e) - (YW+1)'(y1w);
            r3   = c3 ? dely_zero : (y1w > by1e);
            c4   = y2w > by1e;
            a3_s = (YW+1)'(y2w) - (YW+1)'(by1e);
            r4   = c4 ? dely_zero : (y2w < by0e);
        end
        else
        begin
            c3   = y1w > by1e;
            a2_s = (YW+1)'(y1w) - (YW+1)'(by1e);
            r3   = c3 ? dely_zero : (y1w < by0e);
            c4   = y2w < by0e;
            a3_s = (YW+1)'(by0e) - (YW+1)'(y2w);
            r4   = c4 ? dely_zero : (y2w > by1e);
        end
        ys_next.rej = xo.rej || r3 || r4;
        ys_next.c3  = c3;
        ys_next.c4  = c4;
        ys_next.x1  = xo.clip1 ? xo.bx0 : xo.x1;
        ys_next.x2  = xo.clip2 ? xo.bx1 : xo.x2;
        ys_next.y1  = c3 ? (up ? by0e : by1e) : y1w;
        ys_next.y2  = c4 ? (up ? by1e : by0e) : y2w;
        ys_next.bx0 = xo.bx0;
        ys_next.bx1 = xo.bx1;
        ys_next.by0 = xo.by0;
        ys_next.by1 = xo.by1;
    end

    assign y_a[0] = a2_s[AW-1:0];
    assign y_a[1] = a3_s[AW-1:0];
    assign y_b[0] = xo.delx;
    assign y_b[1] = xo.delx;
    assign y_d[0] = xo.dely;
    assign y_d[1] = xo.dely;

    assign y_ctl.advance = advance;
    assign y_ctl.valid   = x_valid;

    lbc_rdiv_pair #(
        .COORD_BITS (COORD_BITS),
        .SIDE_BITS  (YSW)
    ) u_ydiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (y_ctl),
        .a_in      (y_a),
        .b_in      (y_b),
        .d_in      (y_d),
        .side_in   (ys_next),
        .valid_out (y_valid),
        .q_out     (y_q),
        .side_out  (y_side_out)
    );

    assign yo = yside_t'(y_side_out);

    // final endpoints and flags
    logic signed [YW-1:0]     t2, t3, x1e, x2e, x1f, x2f, fbx0, fbx1, fby0, fby1;
    logic                     ok1, ok2, in_box;

    assign t2   = {1'b0, y_q[0]};
    assign t3   = {1'b0, y_q[1]};
    assign x1e  = YW'(yo.x1);
    assign x2e  = YW'(yo.x2);
    assign fbx0 = YW'(yo.bx0);
    assign fbx1 = YW'(yo.bx1);
    assign fby0 = YW'(yo.by0);
    assign fby1 = YW'(yo.by1);
    assign x1f  = yo.c3 ? x1e + t2 : x1e;
    assign x2f  = yo.c4 ? x2e - t3 : x2e;

    always_comb
    begin
        ok1    = (x1f == fbx0) || (yo.y1 == fby0) || (yo.y1 == fby1);
        ok2    = (x2f == fbx1) || (yo.y2 == fby0) || (yo.y2 == fby1);
        in_box = (x1f >= fbx0) && (x1f <= fbx1) && (yo.y1 >= fby0) && (yo.y1 <= fby1);
        visible_next   = !yo.rej && (ok1 || ok2 || in_box);
        first_ok_next  = !yo.rej && ok1;
        second_ok_next = !yo.rej && ok2;
        first_x_next   = first_ok_next  ? x1f[CW-1:0]   : '0;
        first_y_next   = first_ok_next  ? yo.y1[CW-1:0] : '0;
        second_x_next  = second_ok_next ? x2f[CW-1:0]   : '0;
        second_y_next  = second_ok_next ? yo.y2[CW-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= y_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            visible_reg   <= visible_next;
            first_x_reg   <= first_x_next;
            first_y_reg   <= first_y_next;
            first_ok_reg  <= first_ok_next;
            second_x_reg  <= second_x_next;
            second_y_reg  <= second_y_next;
            second_ok_reg <= second_ok_next;
        end
    end

    assign result_valid     = result_valid_reg;
    assign visible          = visible_reg;
    assign first_x          = first_x_reg;
    assign first_y          = first_y_reg;
    assign first_on_border  = first_ok_reg;
    assign second_x         = second_x_reg;
    assign second_y         = second_y_reg;
    assign second_on_border = second_ok_reg;

endmodule

`default_nettype wire

/* hdl/lbc_checker.sv */
// ----------------------------------------------------------------------------
// lbc_checker
// port-level checks for line_box_clip_core, attached by bind
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbc_checker #(
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic                          item_stall,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  logic                          visible,
    input  logic signed [COORD_BITS-1:0]  first_x,
    input  logic signed [COORD_BITS-1:0]  first_y,
    input  logic                          first_on_border,
    input  logic signed [COORD_BITS-1:0]  second_x,
    input  logic signed [COORD_BITS-1:0]  second_y,
    input  logic                          second_on_border
);

    // a stalled result transaction stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(visible)
            && $stable(first_x) && $stable(first_y) && $stable(first_on_border)
            && $stable(second_x) && $stable(second_y) && $stable(second_on_border))
        else $error("stalled result changed");

    // input side only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("item stalled without a stalled result");

    // a border flag implies a visible segment
    a_flag_vis: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !visible |-> !first_on_border && !second_on_border)
        else $error("border flag set on a hidden segment");

    // endpoints without a flag read as zero
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (first_on_border || (first_x == '0 && first_y == '0))
            && (second_on_border || (second_x == '0 && second_y == '0)))
        else $error("unflagged endpoint not zero");

endmodule

bind line_box_clip_core lbc_checker #(.COORD_BITS(COORD_BITS)) u_lbc_checker (.*);

`default_nettype wire
